[rtl/isi_pkg.sv]
package isi_pkg;

    // Field and state widths
    localparam int OP_W    = 1;
    localparam int DELTA_W = 16;
    localparam int DT_W    = 10;
    localparam int PX_W    = 20;
    localparam int POS_W   = 40;
    localparam int VEL_W   = 32;

    // Fixed-point constants (1/256-pixel units)
    localparam int SUBPX_SHIFT   = 8;
    localparam int LIM_W         = PX_W + SUBPX_SHIFT;
    localparam int GAIN_SHIFT    = 4;    // impulse gain of 16
    localparam int DAMP_HI_SHIFT = 8;    // 240 = 256 - 16
    localparam int DAMP_LO_SHIFT = 4;
    localparam int REST_LIMIT    = 64;

    localparam int MAX_STEPS_DEF = 100;

    // Operation codes
    localparam logic [OP_W-1:0] OP_IMPULSE = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK    = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load_impulse;
        logic load_tick;
        logic step;
        logic clamp;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic tick_nonzero;
        logic last_step;
    } status_t;

endpackage

[rtl/inertial_scroll_integrator.sv]
// Inertial scroll integrator: keeps scroll position and velocity in 1/256-pixel
// units and returns one word (whole-pixel scroll_y, active flag) per input word.
// An impulse word, or a tick word with dt_ms of 0, goes from acceptance straight
// to the output load state. A tick word with n = min(dt_ms, MAX_STEPS) steps
// (n >= 1) first runs n integration steps and one clamp step, then the output
// load; the integration datapath runs one millisecond step per cycle. The output
// load waits while the previous output word is still stalled. A new word is
// accepted as soon as the previous one has been handed to the output register,
// even while that word is stalled.
module inertial_scroll_integrator
#(
    parameter int MAX_STEPS = isi_pkg::MAX_STEPS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [isi_pkg::OP_W-1:0]            operation,
    input  logic signed [isi_pkg::DELTA_W-1:0]  flick_px,
    input  logic [isi_pkg::DT_W-1:0]            dt_ms,
    input  logic [isi_pkg::PX_W-1:0]            content_len,
    input  logic [isi_pkg::PX_W-1:0]            window_len,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [isi_pkg::PX_W-1:0]            scroll_y,
    output logic                                active
);

    isi_pkg::cmd_t    cmd;
    isi_pkg::status_t status;

    // Sequencer
    isi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Position/velocity datapath
    isi_dp
    #(
        .MAX_STEPS (MAX_STEPS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .flick_px    (flick_px),
        .dt_ms       (dt_ms),
        .content_len (content_len),
        .window_len  (window_len),
        .scroll_y    (scroll_y),
        .active      (active),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

[rtl/isi_ctrl.sv]
module isi_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [isi_pkg::OP_W-1:0]      operation,
    output logic                          out_valid,
    input  logic                          out_stall,
    input  isi_pkg::status_t              status,
    output isi_pkg::cmd_t                 cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_CLAMP,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && (state_reg == ST_IDLE);

    // Command decode
    always_comb
    begin
        cmd.load_impulse = accept && (operation == isi_pkg::OP_IMPULSE);
        cmd.load_tick    = accept && (operation == isi_pkg::OP_TICK);
        cmd.step         = (state_reg == ST_RUN);
        cmd.clamp        = (state_reg == ST_CLAMP);
        cmd.out_load     = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    // Next state and output word valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load_tick && status.tick_nonzero)
                begin
                    state_next = ST_RUN;
                end
                else if (accept)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN:
            begin
                if (status.last_step)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (cmd.out_load)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/isi_dp.sv]
module isi_dp
#(
    parameter int MAX_STEPS = isi_pkg::MAX_STEPS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [isi_pkg::DELTA_W-1:0]  flick_px,
    input  logic        [isi_pkg::DT_W-1:0]     dt_ms,
    input  logic        [isi_pkg::PX_W-1:0]     content_len,
    input  logic        [isi_pkg::PX_W-1:0]     window_len,
    output logic        [isi_pkg::PX_W-1:0]     scroll_y,
    output logic                                active,
    input  isi_pkg::cmd_t                       cmd,
    output isi_pkg::status_t                    status
);

    localparam int POS_W = isi_pkg::POS_W;
    localparam int VEL_W = isi_pkg::VEL_W;
    localparam int LIM_W = isi_pkg::LIM_W;
    localparam int PX_W  = isi_pkg::PX_W;
    localparam int SH    = isi_pkg::SUBPX_SHIFT;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int IMP_W = VEL_W + 2;

    localparam logic [isi_pkg::DT_W-1:0] MAX_DT = isi_pkg::DT_W'(MAX_STEPS);
    localparam logic signed [VEL_W-1:0]  REST_HI = VEL_W'(isi_pkg::REST_LIMIT);
    localparam logic signed [VEL_W-1:0]  REST_LO = -REST_HI;
    localparam logic signed [POS_W-1:0]  ROUND_BIAS = POS_W'((1 << SH) - 1);
    localparam logic signed [POS_W-1:0]  POS_ZERO = '0;
    localparam logic signed [VEL_W-1:0]  VEL_ZERO = '0;

    logic signed [POS_W-1:0] position_reg;
    logic signed [POS_W-1:0] position_next;
    logic signed [VEL_W-1:0] velocity_reg;
    logic signed [VEL_W-1:0] velocity_next;
    logic        [LIM_W-1:0] limit_reg;
    logic        [LIM_W-1:0] limit_next;
    logic        [CNT_W-1:0] count_reg;
    logic        [CNT_W-1:0] count_next;
    logic        [PX_W-1:0]  scroll_y_reg;
    logic                    active_reg;

    logic        [isi_pkg::DT_W-1:0] dt_clamped;
    logic signed [PX_W:0]            span;
    logic signed [IMP_W-1:0]         imp_sum;
    logic signed [VEL_W-1:0]         imp_sat;
    logic signed [POS_W-1:0]         vel_ext;
    logic signed [POS_W-1:0]         pos_sum;
    logic signed [POS_W-1:0]         damp_prod;
    logic signed [POS_W-1:0]         damp_biased;
    logic signed [POS_W-1:0]         damp_q;
    logic signed [VEL_W-1:0]         vel_damped;
    logic signed [POS_W-1:0]         limit_ext;

    assign scroll_y = scroll_y_reg;
    assign active   = active_reg;

    // Tick setup: step count and upper bound
    assign dt_clamped = (dt_ms > MAX_DT) ? MAX_DT : dt_ms;
    assign span       = $signed({1'b0, content_len}) - $signed({1'b0, window_len});
    assign limit_ext  = $signed({{(POS_W - LIM_W){1'b0}}, limit_reg});

    assign status.tick_nonzero = (dt_ms != '0);
    assign status.last_step    = (count_reg == CNT_W'(1));

    // Impulse: velocity += delta * 16, saturating
    assign imp_sum = IMP_W'(velocity_reg)
                   + (IMP_W'(flick_px) <<< isi_pkg::GAIN_SHIFT);
    always_comb
    begin
        if (imp_sum[IMP_W-1:VEL_W-1] == '0 || imp_sum[IMP_W-1:VEL_W-1] == '1)
        begin
            imp_sat = imp_sum[VEL_W-1:0];
        end
        else if (imp_sum[IMP_W-1])
        begin
            imp_sat = {1'b1, {(VEL_W-1){1'b0}}};
        end
        else
        begin
            imp_sat = {1'b0, {(VEL_W-1){1'b1}}};
        end
    end

    // One millisecond step: integrate, damp by 240/256 toward zero
    assign vel_ext     = POS_W'(velocity_reg);
    assign pos_sum     = position_reg + vel_ext;
    assign damp_prod   = (vel_ext <<< isi_pkg::DAMP_HI_SHIFT)
                       - (vel_ext <<< isi_pkg::DAMP_LO_SHIFT);
    assign damp_biased = damp_prod[POS_W-1] ? (damp_prod + ROUND_BIAS) : damp_prod;
    assign damp_q      = damp_biased >>> SH;
    assign vel_damped  = damp_q[VEL_W-1:0];

    // Next state of position, velocity, bound and counter
    always_comb
    begin
        position_next = position_reg;
        velocity_next = velocity_reg;
        limit_next    = limit_reg;
        count_next    = count_reg;
        if (cmd.load_impulse)
        begin
            velocity_next = imp_sat;
        end
        if (cmd.load_tick)
        begin
            count_next = CNT_W'(dt_clamped);
            limit_next = span[PX_W] ? '0 : {span[PX_W-1:0], {SH{1'b0}}};
        end
        if (cmd.step)
        begin
            position_next = pos_sum;
            count_next    = count_reg - CNT_W'(1);
            velocity_next = vel_damped;
            // kill outward motion at either boundary
            if (pos_sum <= POS_ZERO && vel_damped < VEL_ZERO)
            begin
                velocity_next = '0;
            end
            if (pos_sum >= limit_ext && vel_damped > VEL_ZERO)
            begin
                velocity_next = '0;
            end
        end
        if (cmd.clamp)
        begin
            if (position_reg < POS_ZERO)
            begin
                position_next = '0;
            end
            else if (position_reg > limit_ext)
            begin
                position_next = limit_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            velocity_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            position_reg <= position_next;
            velocity_reg <= velocity_next;
            count_reg    <= count_next;
        end
    end

    // Bound and output word registers
    always_ff @(posedge clk)
    begin
        limit_reg <= limit_next;
        if (cmd.out_load)
        begin
            scroll_y_reg <= position_reg[POS_W-1] ? '0 : position_reg[SH +: PX_W];
            active_reg   <= (velocity_reg >= REST_HI) || (velocity_reg <= REST_LO);
        end
    end

endmodule

[bench/tb_inertial_scroll_integrator.sv]
module tb_inertial_scroll_integrator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W        = isi_pkg::OP_W;
    localparam int DELTA_W     = isi_pkg::DELTA_W;
    localparam int DT_W        = isi_pkg::DT_W;
    localparam int PX_W        = isi_pkg::PX_W;
    localparam int VEL_W       = isi_pkg::VEL_W;
    localparam int SUBPX_SHIFT = isi_pkg::SUBPX_SHIFT;
    localparam int REST_LIMIT  = isi_pkg::REST_LIMIT;

    localparam int     STEP_CAP  = isi_pkg::MAX_STEPS_DEF;
    localparam int     RUN_LIMIT = 1_000_000;
    localparam longint VEL_MAX   = (longint'(1) <<< (VEL_W - 1)) - 1;
    localparam longint VEL_MIN   = -(longint'(1) <<< (VEL_W - 1));

    localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7FFF;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = 16'sh8000;
    localparam logic [PX_W-1:0]           PX_MAX    = '1;

    // One input word and the view it should produce
    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [DELTA_W-1:0] delta;
        logic [DT_W-1:0]           dt;
        logic [PX_W-1:0]           content;
        logic [PX_W-1:0]           viewport;
    } scroll_word_t;

    typedef struct {
        logic [PX_W-1:0] scroll_y;
        logic            active;
    } view_state_t;

    logic                      clk;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic [OP_W-1:0]           operation   = '0;
    logic signed [DELTA_W-1:0] flick_px    = '0;
    logic [DT_W-1:0]           dt_ms       = '0;
    logic [PX_W-1:0]           content_len = '0;
    logic [PX_W-1:0]           window_len  = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [PX_W-1:0]           scroll_y;
    logic                      active;

    scroll_word_t scroll_words[$];
    view_state_t  expected_views[$];

    // Tracked copy of the block's state
    longint track_pos = 0;
    longint track_vel = 0;

    int unsigned words_offered = 0;
    int unsigned words_taken   = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned idle_pct      = 21;

    inertial_scroll_integrator dut (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Apply one word to the tracked state and return the resulting view
    function automatic view_state_t integrate_word(scroll_word_t w);
        view_state_t r;
        longint      v;
        longint      span;
        longint      lim;
        longint      mag;
        int unsigned steps;
        if (w.op == isi_pkg::OP_IMPULSE)
        begin
            v = track_vel + longint'(w.delta) * 16;
            if (v > VEL_MAX)
                v = VEL_MAX;
            if (v < VEL_MIN)
                v = VEL_MIN;
            track_vel = v;
        end
        else
        begin
            steps = (w.dt > STEP_CAP) ? STEP_CAP : w.dt;
            if (steps != 0)
            begin
                span = longint'(w.content) - longint'(w.viewport);
                if (span < 0)
                    span = 0;
                lim = span * 256;
                for (int unsigned k = 0; k < steps; k++)
                begin
                    track_pos += track_vel;
                    // signed divide truncates toward zero
                    track_vel = (track_vel * 240) / 256;
                    if (track_pos <= 0 && track_vel < 0)
                        track_vel = 0;
                    if (track_pos >= lim && track_vel > 0)
                        track_vel = 0;
                end
                if (track_pos < 0)
                    track_pos = 0;
                if (track_pos > lim)
                    track_pos = lim;
            end
        end
        mag        = (track_vel < 0) ? -track_vel : track_vel;
        r.scroll_y = (track_pos < 0) ? '0 : PX_W'(track_pos >>> SUBPX_SHIFT);
        r.active   = (mag >= REST_LIMIT);
        return r;
    endfunction

    function automatic scroll_word_t impulse_word(logic signed [DELTA_W-1:0] d);
        scroll_word_t w;
        w.op       = isi_pkg::OP_IMPULSE;
        w.delta    = d;
        // fields an impulse ignores carry junk
        w.dt       = DT_W'($urandom);
        w.content  = PX_W'($urandom);
        w.viewport = PX_W'($urandom);
        return w;
    endfunction

    function automatic scroll_word_t tick_word(int unsigned dt, logic [PX_W-1:0] c,
                                               logic [PX_W-1:0] vp);
        scroll_word_t w;
        w.op       = isi_pkg::OP_TICK;
        w.delta    = DELTA_W'($urandom);
        w.dt       = DT_W'(dt);
        w.content  = c;
        w.viewport = vp;
        return w;
    endfunction

    function automatic logic signed [DELTA_W-1:0] rand_delta();
        int mag;
        case ($urandom_range(9))
            0:       return DELTA_W'($urandom);
            1, 2:    mag = $urandom_range(1, 30);
            default: mag = $urandom_range(20, 400);
        endcase
        return $urandom_range(1) ? DELTA_W'(mag) : DELTA_W'(-mag);
    endfunction

    function automatic int unsigned rand_dt();
        case ($urandom_range(19))
            0:       return 0;
            1, 2:    return $urandom_range(STEP_CAP + 1, 1023);
            3, 4, 5: return $urandom_range(17, STEP_CAP);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    // Flick gestures: an occasional random word, a few impulses, then frame ticks over one geometry
    task automatic queue_gestures(int unsigned n_words);
        int unsigned     queued;
        int unsigned     n_imp;
        int unsigned     n_tick;
        logic [PX_W-1:0] c;
        logic [PX_W-1:0] vp;
        scroll_word_t    junk;
        queued = 0;
        while (queued < n_words)
        begin
            case ($urandom_range(9))
                0:
                begin
                    c  = PX_W'($urandom);
                    vp = PX_W'($urandom);
                end
                1:
                begin
                    vp = PX_W'($urandom_range(400, 2000));
                    c  = PX_W'($urandom_range(0, 32'(vp)));
                end
                2:
                begin
                    c  = PX_MAX;
                    vp = '0;
                end
                default:
                begin
                    vp = PX_W'($urandom_range(200, 2000));
                    c  = vp + PX_W'($urandom_range(1, 8000));
                end
            endcase
            if ($urandom_range(9) == 0)
            begin
                junk.op       = OP_W'($urandom_range(1));
                junk.delta    = DELTA_W'($urandom);
                junk.dt       = DT_W'($urandom);
                junk.content  = PX_W'($urandom);
                junk.viewport = PX_W'($urandom);
                scroll_words.push_back(junk);
                queued++;
            end
            n_imp  = $urandom_range(3);
            n_tick = $urandom_range(1, 6);
            repeat (n_imp)
            begin
                scroll_words.push_back(impulse_word(rand_delta()));
                queued++;
            end
            repeat (n_tick)
            begin
                scroll_words.push_back(tick_word(rand_dt(), c, vp));
                queued++;
            end
        end
    endtask

    task automatic wait_drained();
        while (scroll_words.size() != 0 || words_taken != words_offered ||
               expected_views.size() != 0)
            @(posedge clk);
    endtask

    // Driver: offers the next word at the falling edge, holds it until taken
    always @(negedge clk)
    begin
        scroll_word_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < idle_pct);
            if (!in_valid || words_taken == words_offered)
            begin
                if (scroll_words.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = scroll_words.pop_front();
                    operation   <= nxt.op;
                    flick_px    <= nxt.delta;
                    dt_ms       <= nxt.dt;
                    content_len <= nxt.content;
                    window_len  <= nxt.viewport;
                    in_valid    <= 1'b1;
                    words_offered++;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks output words and predicts for accepted input words
    always @(posedge clk)
    begin
        view_state_t  want;
        scroll_word_t got;
        cycle_cnt++;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("output word with nothing expected: scroll_y %0d active %0b",
                           scroll_y, active);
                    mismatches++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (scroll_y !== want.scroll_y)
                    begin
                        $error("scroll_y: expected %0d, actual %0d", want.scroll_y, scroll_y);
                        mismatches++;
                    end
                    if (active !== want.active)
                    begin
                        $error("active: expected %0b, actual %0b", want.active, active);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                got = '{operation, flick_px, dt_ms, content_len, window_len};
                expected_views.push_back(integrate_word(got));
                words_taken++;
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_cnt < RUN_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and the corner cases
        scroll_words.push_back(tick_word(0, PX_MAX, '0));         // zero tick out of reset
        scroll_words.push_back(impulse_word(DELTA_MAX));
        scroll_words.push_back(tick_word(1, PX_MAX, '0));
        scroll_words.push_back(tick_word(1023, PX_MAX, '0));      // long tick
        scroll_words.push_back(impulse_word(DELTA_MIN));
        scroll_words.push_back(tick_word(STEP_CAP, PX_MAX, '0));  // runs into the top edge
        scroll_words.push_back(impulse_word(16'sd0));
        scroll_words.push_back(impulse_word(16'sd4));             // right at the rest limit
        scroll_words.push_back(impulse_word(-16'sd1));
        scroll_words.push_back(impulse_word(-16'sd7));
        scroll_words.push_back(tick_word(STEP_CAP + 1, PX_MAX, '0));
        scroll_words.push_back(impulse_word(16'sd300));
        scroll_words.push_back(tick_word(20, 20'd800, 20'd500));
        scroll_words.push_back(tick_word(0, 20'd500, 20'd800));   // zero tick skips the clamp
        scroll_words.push_back(tick_word(5, 20'd500, 20'd800));   // short content
        scroll_words.push_back(impulse_word(16'sd500));
        scroll_words.push_back(tick_word(10, 20'd600, 20'd600));  // content equals viewport
        scroll_words.push_back(tick_word(3, '0, PX_MAX));
        scroll_words.push_back(impulse_word(16'sd1000));
        scroll_words.push_back(tick_word(50, 20'd1200, 20'd300)); // bottom edge
        scroll_words.push_back(impulse_word(DELTA_MIN));
        scroll_words.push_back(tick_word(1, PX_MAX, '0));
        wait_drained();

        // Random gestures, then again with no idle gaps or output stalls; each batch drains first
        queue_gestures(600);
        wait_drained();
        idle_pct = 0;
        queue_gestures(600);
        wait_drained();
        idle_pct = 21;

        repeat (STEP_CAP + 10) @(posedge clk);
        if (mismatches == 0 && expected_views.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
